FILE: hdl/lkst_pkg.sv
// Shared types and codes for the LRU key slot table.
`timescale 1ns / 1ps

package lkst_pkg;

    localparam int KEY_W     = 48;
    localparam int EVICT_W   = 32;
    localparam int INDEX_W   = 3;
    localparam int OUTCOME_W = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;

    localparam logic [OUTCOME_W-1:0] OUTCOME_NULL  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_CLAIM = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd3;

    typedef struct packed {
        logic active;
        logic hit;
        logic free;
    } lkst_flags_t;

endpackage

FILE: hdl/lru_key_slot_table_top.sv
// Top level of the LRU key slot table: request control and the chain of slot cells.
//
// Requests arrive one word at a time on s_axis: tdata carries the key. Each
// result leaves on m_axis: tdata carries the slot index and the running
// eviction count, tuser carries the valid flag and the outcome code.
// A nonzero key enters a chain of SLOTS cells, one cell per cycle; each cell
// holds one slot and hands the search word to its neighbour. At the end of
// the chain the slot is chosen and written back in the same cycle.
// A nonzero key passes through S_SWEEP and then S_DONE, where the result is
// registered for output; a zero key goes from S_IDLE straight to S_DONE. A new
// request is taken only once the previous one has left S_DONE, so for a nonzero
// key the walk along the cell chain sets when the next request can be taken.
// s_axis_tready is high only while no request is in flight.
// The result register holds until m_axis_tready; a finished result waits
// until it is free, and no further request is taken meanwhile.
// Reset clears all slots to free, all stamps and both counters to zero.
`timescale 1ns / 1ps

module lru_key_slot_table_top #(
    parameter int SLOTS      = 8,
    parameter int KEY_BITS   = 48,
    parameter int STAMP_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [47:0] key
    input  logic [lkst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] slot_index, [34:3] evictions_total, [39:35] zero
    output logic [lkst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] slot_valid, [2:1] outcome
    output logic [lkst_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import lkst_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [STAMP_BITS-1:0] use_cnt_reg;
    logic [EVICT_W-1:0]    evict_cnt_reg;

    logic                  pend_valid_reg;
    logic [INDEX_W-1:0]    pend_index_reg;
    logic [OUTCOME_W-1:0]  pend_outcome_reg;

    logic                  out_valid_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic [OUTCOME_W-1:0]  out_outcome_reg;
    logic [EVICT_W-1:0]    out_evict_reg;
    logic                  out_tvalid_reg;

    logic [KEY_BITS+KEY_W-1:0] key_ext;
    logic [KEY_BITS-1:0]       key_in;
    logic                      accept;
    logic                      key_null;

    lkst_flags_t           flags_c     [SLOTS+1];
    logic [KEY_BITS-1:0]   key_c       [SLOTS+1];
    logic [IDX_W-1:0]      hit_idx_c   [SLOTS+1];
    logic [IDX_W-1:0]      free_idx_c  [SLOTS+1];
    logic [IDX_W-1:0]      min_idx_c   [SLOTS+1];
    logic [STAMP_BITS-1:0] min_stamp_c [SLOTS+1];

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [OUTCOME_W-1:0]  wr_outcome;
    logic [IDX_W+INDEX_W-1:0] wr_idx_ext;

    assign key_ext  = {{KEY_BITS{1'b0}}, s_axis_tdata[KEY_W-1:0]};
    assign key_in   = key_ext[KEY_BITS-1:0];
    assign key_null = (key_in == '0);
    assign accept   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        flags_c[0].active = accept && !key_null;
        flags_c[0].hit    = 1'b0;
        flags_c[0].free   = 1'b0;
        key_c[0]          = key_in;
        hit_idx_c[0]      = '0;
        free_idx_c[0]     = '0;
        min_idx_c[0]      = '0;
        min_stamp_c[0]    = '0;
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        lkst_cell #(
            .IDX        (g),
            .IDX_W      (IDX_W),
            .KEY_BITS   (KEY_BITS),
            .STAMP_BITS (STAMP_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .in_flags      (flags_c[g]),
            .in_key        (key_c[g]),
            .in_hit_idx    (hit_idx_c[g]),
            .in_free_idx   (free_idx_c[g]),
            .in_min_idx    (min_idx_c[g]),
            .in_min_stamp  (min_stamp_c[g]),
            .wr_en         (wr_en),
            .wr_idx        (wr_idx),
            .wr_key        (key_c[SLOTS]),
            .wr_stamp      (use_cnt_reg),
            .out_flags     (flags_c[g+1]),
            .out_key       (key_c[g+1]),
            .out_hit_idx   (hit_idx_c[g+1]),
            .out_free_idx  (free_idx_c[g+1]),
            .out_min_idx   (min_idx_c[g+1]),
            .out_min_stamp (min_stamp_c[g+1])
        );
    end

    always_comb
    begin
        wr_en = (state_reg == S_SWEEP) && flags_c[SLOTS].active;
        if (flags_c[SLOTS].hit)
        begin
            wr_idx     = hit_idx_c[SLOTS];
            wr_outcome = OUTCOME_HIT;
        end
        else if (flags_c[SLOTS].free)
        begin
            wr_idx     = free_idx_c[SLOTS];
            wr_outcome = OUTCOME_CLAIM;
        end
        else
        begin
            wr_idx     = min_idx_c[SLOTS];
            wr_outcome = OUTCOME_EVICT;
        end
        wr_idx_ext = {{INDEX_W{1'b0}}, wr_idx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            use_cnt_reg      <= '0;
            evict_cnt_reg    <= '0;
            out_tvalid_reg   <= 1'b0;
            pend_valid_reg   <= 1'b0;
            pend_index_reg   <= '0;
            pend_outcome_reg <= OUTCOME_NULL;
            out_valid_reg    <= 1'b0;
            out_index_reg    <= '0;
            out_outcome_reg  <= OUTCOME_NULL;
            out_evict_reg    <= '0;
        end
        else
        begin
            if (out_tvalid_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                out_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (key_null)
                        begin
                            pend_valid_reg   <= 1'b0;
                            pend_index_reg   <= '0;
                            pend_outcome_reg <= OUTCOME_NULL;
                            state_reg        <= S_DONE;
                        end
                        else
                        begin
                            use_cnt_reg <= use_cnt_reg + 1'b1;
                            state_reg   <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP:
                begin
                    if (wr_en)
                    begin
                        pend_valid_reg   <= 1'b1;
                        pend_index_reg   <= wr_idx_ext[INDEX_W-1:0];
                        pend_outcome_reg <= wr_outcome;
                        if (wr_outcome == OUTCOME_EVICT)
                        begin
                            evict_cnt_reg <= evict_cnt_reg + 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_tvalid_reg || m_axis_tready)
                    begin
                        out_valid_reg   <= pend_valid_reg;
                        out_index_reg   <= pend_index_reg;
                        out_outcome_reg <= pend_outcome_reg;
                        out_evict_reg   <= evict_cnt_reg;
                        out_tvalid_reg  <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_tvalid_reg;
    assign m_axis_tdata  = {5'b0, out_evict_reg, out_index_reg};
    assign m_axis_tuser  = {out_outcome_reg, out_valid_reg};

endmodule

FILE: hdl/lkst_cell.sv
// One slot of the table: owner, stamp and one stage of the search chain.
`timescale 1ns / 1ps

module lkst_cell #(
    parameter int IDX        = 0,
    parameter int IDX_W      = 3,
    parameter int KEY_BITS   = 48,
    parameter int STAMP_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lkst_pkg::lkst_flags_t   in_flags,
    input  logic [KEY_BITS-1:0]     in_key,
    input  logic [IDX_W-1:0]        in_hit_idx,
    input  logic [IDX_W-1:0]        in_free_idx,
    input  logic [IDX_W-1:0]        in_min_idx,
    input  logic [STAMP_BITS-1:0]   in_min_stamp,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  logic [KEY_BITS-1:0]     wr_key,
    input  logic [STAMP_BITS-1:0]   wr_stamp,
    output lkst_pkg::lkst_flags_t   out_flags,
    output logic [KEY_BITS-1:0]     out_key,
    output logic [IDX_W-1:0]        out_hit_idx,
    output logic [IDX_W-1:0]        out_free_idx,
    output logic [IDX_W-1:0]        out_min_idx,
    output logic [STAMP_BITS-1:0]   out_min_stamp
);
    import lkst_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [KEY_BITS-1:0]   owner_reg;
    logic [STAMP_BITS-1:0] stamp_reg;

    lkst_flags_t           flags_reg, flags_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]      min_idx_reg, min_idx_next;
    logic [STAMP_BITS-1:0] min_stamp_reg, min_stamp_next;

    logic own_hit;
    logic own_free;
    logic own_min;

    assign own_hit  = !in_flags.hit && (owner_reg == in_key);
    assign own_free = !in_flags.free && (owner_reg == '0);
    assign own_min  = (IDX == 0) || (stamp_reg < in_min_stamp);

    always_comb
    begin
        flags_next.active = in_flags.active;
        flags_next.hit    = in_flags.hit || own_hit;
        flags_next.free   = in_flags.free || own_free;
        hit_idx_next      = own_hit ? MY_IDX : in_hit_idx;
        free_idx_next     = own_free ? MY_IDX : in_free_idx;
        min_idx_next      = own_min ? MY_IDX : in_min_idx;
        min_stamp_next    = own_min ? stamp_reg : in_min_stamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
            stamp_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            if (wr_en && (wr_idx == MY_IDX))
            begin
                owner_reg <= wr_key;
                stamp_reg <= wr_stamp;
            end
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= in_key;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        min_idx_reg   <= min_idx_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign out_flags     = flags_reg;
    assign out_key       = key_reg;
    assign out_hit_idx   = hit_idx_reg;
    assign out_free_idx  = free_idx_reg;
    assign out_min_idx   = min_idx_reg;
    assign out_min_stamp = min_stamp_reg;

endmodule

FILE: verif/lru_key_slot_table_top_tb.sv
// Self-checking testbench for the LRU key slot table: directed and random keys against a slot predictor.
`timescale 1ns / 1ps

module lru_key_slot_table_top_tb;

    import lkst_pkg::*;

    localparam int NUM_SLOTS    = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int KEY_POOL_N   = 11;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 4;

    typedef struct packed {
        logic                  valid;
        logic [INDEX_W-1:0]    index;
        logic [OUTCOME_W-1:0]  outcome;
        logic [EVICT_W-1:0]    evictions;
    } slot_grant_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              typed;
        slot_grant_t       want;
    } key_row_t;

    localparam int DIRECTED_N = 17;

    logic clk;
    logic rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;

    logic [KEY_W-1:0]    tbl_owner [NUM_SLOTS];
    logic [31:0]         tbl_stamp [NUM_SLOTS];
    logic [31:0]         use_count;
    logic [EVICT_W-1:0]  evict_count;

    slot_grant_t grant_q [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;

    key_row_t directed_rows [DIRECTED_N] = '{
        '{48'h0000_0000_0000, 1'b1, '{1'b0, 3'd0, OUTCOME_NULL,  32'd0}},
        '{48'h0000_0000_0001, 1'b1, '{1'b1, 3'd0, OUTCOME_CLAIM, 32'd0}},
        '{48'hFFFF_FFFF_FFFF, 1'b1, '{1'b1, 3'd1, OUTCOME_CLAIM, 32'd0}},
        '{48'h0000_0000_0001, 1'b1, '{1'b1, 3'd0, OUTCOME_HIT,   32'd0}},
        '{48'h8000_0000_0001, 1'b1, '{1'b1, 3'd2, OUTCOME_CLAIM, 32'd0}},
        '{48'h0000_0000_0000, 1'b1, '{1'b0, 3'd0, OUTCOME_NULL,  32'd0}},
        '{48'h0000_0000_0002, 1'b0, '0},
        '{48'h5555_5555_5555, 1'b0, '0},
        '{48'hAAAA_AAAA_AAAA, 1'b0, '0},
        '{48'h0000_0001_0000, 1'b0, '0},
        '{48'h7FFF_FFFF_FFFF, 1'b0, '0},
        '{48'h0000_0000_0003, 1'b0, '0},
        '{48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{48'h0000_0000_0001, 1'b0, '0},
        '{48'h0000_0000_0003, 1'b0, '0},
        '{48'h0000_0000_0000, 1'b0, '0},
        '{48'h8000_0000_0000, 1'b0, '0}
    };

    lru_key_slot_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic slot_grant_t grant_slot(input logic [KEY_W-1:0] key);
        slot_grant_t g;
        int          pick;
        g.valid     = 1'b0;
        g.index     = '0;
        g.outcome   = OUTCOME_NULL;
        g.evictions = evict_count;
        if (key == '0)
            return g;
        use_count = use_count + 32'd1;
        pick = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (pick < 0 && tbl_owner[i] == key)
            begin
                pick = i;
                g.outcome = OUTCOME_HIT;
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (pick < 0 && tbl_owner[i] == '0)
            begin
                pick = i;
                g.outcome = OUTCOME_CLAIM;
            end
        end
        if (pick < 0)
        begin
            pick = 0;
            for (int i = 1; i < NUM_SLOTS; i++)
            begin
                if (tbl_stamp[i] < tbl_stamp[pick])
                    pick = i;
            end
            g.outcome = OUTCOME_EVICT;
            evict_count = evict_count + 1'b1;
        end
        tbl_owner[pick] = key;
        tbl_stamp[pick] = use_count;
        g.valid     = 1'b1;
        g.index     = pick[INDEX_W-1:0];
        g.evictions = evict_count;
        return g;
    endfunction

    task automatic send_key(input logic [KEY_W-1:0] key, input logic typed,
                            input slot_grant_t want);
        slot_grant_t predicted;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        do @(posedge clk); while (!s_axis_tready);
        predicted = grant_slot(key);
        grant_q.push_back(typed ? want : predicted);
    endtask

    task automatic hold_sender(input int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            hold_sender($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 5);
        end
    endtask

    task automatic drain_results();
        hold_sender(1);
        while (grant_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        slot_grant_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (grant_q.size() == 0)
            begin
                $error("result word with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = grant_q.pop_front();
                check_field("slot_valid", want.valid, m_axis_tuser[0]);
                check_field("outcome", want.outcome, m_axis_tuser[2:1]);
                check_field("slot_index", want.index, m_axis_tdata[INDEX_W-1:0]);
                check_field("evictions_total", want.evictions,
                            m_axis_tdata[INDEX_W+EVICT_W-1:INDEX_W]);
                check_field("tdata_pad", '0,
                            m_axis_tdata[OUT_DATA_W-1:INDEX_W+EVICT_W]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: long ready stretches, random chatter and hard stalls
    initial
    begin : drive_ready
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = (mode == 2) ? $urandom_range(1, 24) : $urandom_range(1, 40);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= 1'b0;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0] key_pool [KEY_POOL_N];
        logic [KEY_W-1:0] key;
        logic [63:0]      wide;
        int               pick;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_owner[i] = '0;
            tbl_stamp[i] = '0;
        end
        use_count   = '0;
        evict_count = '0;
        for (int i = 0; i < KEY_POOL_N; i++)
        begin
            wide = {$urandom, $urandom};
            key_pool[i] = wide[KEY_W-1:0] | 48'h1;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            send_key(directed_rows[r].key, directed_rows[r].typed, directed_rows[r].want);
            pace_sender();
        end
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            wide = {$urandom, $urandom};
            if (pick < 12)
                key = '0;
            else if (pick < 70)
                key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
            else if (pick < 80)
                key = key_pool[$urandom_range(0, KEY_POOL_N - 1)]
                      ^ (48'h1 << $urandom_range(0, KEY_W - 1));
            else
                key = wide[KEY_W-1:0];
            send_key(key, 1'b0, '0);
            if (n % 100 == 50)
                drain_results();
            else
                pace_sender();
        end

        hold_sender(1);
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (grant_q.size() != 0)
        begin
            $error("%0d result words never arrived", grant_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
